// ----- rtl/hysteresis_peak_counter_core_defines.svh -----
// Assertion macros used by the checker of the peak counter.
`ifndef HYSTERESIS_PEAK_COUNTER_CORE_DEFINES_SVH
`define HYSTERESIS_PEAK_COUNTER_CORE_DEFINES_SVH

// Concurrent assertion, switched off while reset is held.
`define HPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also runs through reset.
`define HPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/hpc_pkg.sv -----
// Shared types, codes and helper functions of the hysteresis peak counter.
`default_nettype none

package hpc_pkg;

    // Width of every configuration register.
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int OUT_COUNT_WIDTH = 16;
    localparam int QUEUE_DEPTH     = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_MIN_PEAKS      = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_MAX_PEAKS      = 2'd3;

    // Reset values of the configuration registers.
    localparam logic signed [CFG_WIDTH-1:0] LOW_THRESHOLD_RST  = 16'sd0;
    localparam logic signed [CFG_WIDTH-1:0] HIGH_THRESHOLD_RST = 16'sd4096;
    localparam logic [CFG_WIDTH-1:0]        MIN_PEAKS_RST      = 16'd0;
    localparam logic [CFG_WIDTH-1:0]        MAX_PEAKS_RST      = 16'hFFFF;

    // Result codes.
    typedef enum logic [1:0] {
        VERDICT_NO_HAND   = 2'd0,
        VERDICT_HAND      = 2'd1,
        VERDICT_TOO_SHORT = 2'd2
    } t_verdict;

    // Slope sign codes (two's complement of -1, 0, +1).
    typedef enum logic [1:0] {
        SIGN_ZERO = 2'b00,
        SIGN_POS  = 2'b01,
        SIGN_NEG  = 2'b11
    } t_sign;

    // How many samples of the current sequence the front has seen.
    typedef enum logic [1:0] {
        SEEN_NONE = 2'd0,
        SEEN_ONE  = 2'd1,
        SEEN_MANY = 2'd2
    } t_seen;

    // Work flags of one queued entry.
    typedef struct packed {
        logic op1_valid;   // track the older sample
        logic op2_valid;   // track the previous sample (end of sequence)
        logic last;        // entry closes the sequence and yields a result
        logic too_short;   // sequence held a single sample
    } t_op_flags;

    // Configuration register set.
    typedef struct packed {
        logic signed [CFG_WIDTH-1:0] low_threshold;
        logic signed [CFG_WIDTH-1:0] high_threshold;
        logic [CFG_WIDTH-1:0]        min_peaks;
        logic [CFG_WIDTH-1:0]        max_peaks;
    } t_cfg;

    // Sign code from the two compare results.
    function automatic t_sign sign_code(input logic gt, input logic lt);
        t_sign s;
        if (gt) begin
            s = SIGN_POS;
        end else if (lt) begin
            s = SIGN_NEG;
        end else begin
            s = SIGN_ZERO;
        end
        return s;
    endfunction

    // Product of two signs is zero or negative: a turning point or a flat.
    function automatic logic is_turn(input t_sign a, input t_sign b);
        return (a == SIGN_ZERO) || (b == SIGN_ZERO) || (a != b);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hysteresis_peak_counter_core.sv -----
// Top level of the hysteresis peak counter: config registers, front, queue, back.
// One curvature sample is taken every clock cycle while input stall is low; a
// result beat (verdict and peak count) follows the sample flagged last through the
// queue and the result register when the output is free. The front end forms slope
// signs and sends tracker work through a four-entry queue to the back end, which
// applies both tracker updates of a sample in one combinational tracker step. Input
// stall rises only when the queue fills because the result register is held by
// output stall. Configuration may be written only while no sequence is in flight.
`default_nettype none

module hysteresis_peak_counter_core
    import hpc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_last,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [1:0]                          o_verdict,
    output logic [OUT_COUNT_WIDTH-1:0]          o_peak_count,
    input  wire logic                           i_cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0]     i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0]           i_cfg_data
);

    localparam int FLAG_W = $bits(t_op_flags);
    localparam int Q_W    = FLAG_W + 2 * SAMPLE_WIDTH;

    t_cfg r_cfg;

    logic                           q_full, q_valid, push, pop;
    t_op_flags                      f_flags, b_flags;
    logic signed [SAMPLE_WIDTH-1:0] f_cur1, f_cur2, b_cur1, b_cur2;
    logic [Q_W-1:0]                 q_wdata, q_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold  <= LOW_THRESHOLD_RST;
            r_cfg.high_threshold <= HIGH_THRESHOLD_RST;
            r_cfg.min_peaks      <= MIN_PEAKS_RST;
            r_cfg.max_peaks      <= MAX_PEAKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_LOW_THRESHOLD:  r_cfg.low_threshold  <= i_cfg_data;
                CFG_IDX_HIGH_THRESHOLD: r_cfg.high_threshold <= i_cfg_data;
                CFG_IDX_MIN_PEAKS:      r_cfg.min_peaks      <= i_cfg_data;
                CFG_IDX_MAX_PEAKS:      r_cfg.max_peaks      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hpc_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sample   (i_sample),
        .i_last     (i_last),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_flags    (f_flags),
        .o_cur1     (f_cur1),
        .o_cur2     (f_cur2)
    );

    // Queue entry packing
    assign q_wdata = {f_flags, f_cur1, f_cur2};
    assign b_flags = t_op_flags'(q_rdata[Q_W-1 -: FLAG_W]);
    assign b_cur1  = q_rdata[2*SAMPLE_WIDTH-1 -: SAMPLE_WIDTH];
    assign b_cur2  = q_rdata[SAMPLE_WIDTH-1:0];

    hpc_queue #(
        .DATA_WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata),
        .i_pop   (pop)
    );

    hpc_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_flags      (b_flags),
        .i_cur1       (b_cur1),
        .i_cur2       (b_cur2),
        .o_pop        (pop),
        .i_cfg        (r_cfg),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_verdict    (o_verdict),
        .o_peak_count (o_peak_count)
    );

endmodule

`default_nettype wire

// ----- rtl/hpc_front.sv -----
// Front end: accepts samples, forms slope signs and classifies tracker work.
`default_nettype none

module hpc_front
    import hpc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_last,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output t_op_flags                           o_flags,
    output logic signed [SAMPLE_WIDTH-1:0]      o_cur1,
    output logic signed [SAMPLE_WIDTH-1:0]      o_cur2
);

    t_seen                          r_seen, n_seen;
    t_sign                          r_sign, n_sign;
    logic signed [SAMPLE_WIDTH-1:0] r_older, n_older;
    logic signed [SAMPLE_WIDTH-1:0] r_prev, n_prev;

    logic  accept;
    t_sign d_old;
    t_sign d_prev;

    // Classify the beat and work out the next sequence state
    always_comb begin
        accept  = i_in_valid && !i_q_full;
        d_old   = sign_code(i_sample > r_older, i_sample < r_older);
        d_prev  = sign_code(i_sample > r_prev, i_sample < r_prev);
        o_flags = '0;
        o_cur1  = r_older;
        o_cur2  = r_prev;
        n_seen  = r_seen;
        n_sign  = r_sign;
        n_older = r_older;
        n_prev  = r_prev;

        case (r_seen)
            SEEN_NONE: begin
                if (i_last) begin
                    o_flags.last      = 1'b1;
                    o_flags.too_short = 1'b1;
                end else begin
                    n_prev = i_sample;
                    n_seen = SEEN_ONE;
                end
            end
            SEEN_ONE: begin
                n_sign = d_prev;
                if (i_last) begin
                    o_flags.last      = 1'b1;
                    o_flags.op2_valid = is_turn(d_prev, d_prev);
                    n_seen            = SEEN_NONE;
                end else begin
                    n_older = r_prev;
                    n_prev  = i_sample;
                    n_seen  = SEEN_MANY;
                end
            end
            SEEN_MANY: begin
                n_sign            = d_old;
                o_flags.op1_valid = is_turn(r_sign, d_old);
                if (i_last) begin
                    o_flags.last      = 1'b1;
                    o_flags.op2_valid = is_turn(d_old, d_prev);
                    n_seen            = SEEN_NONE;
                end else begin
                    n_older = r_prev;
                    n_prev  = i_sample;
                end
            end
            default: begin
                n_seen = SEEN_NONE;
            end
        endcase

        // only beats with tracker work or a result go to the queue
        o_push     = accept && (o_flags.op1_valid || o_flags.last);
        o_in_stall = i_q_full;
    end

    // Sequence control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= SEEN_NONE;
        end else if (accept) begin
            r_seen <= n_seen;
        end
    end

    // Sample history, read only once the count says it is valid
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sign  <= n_sign;
            r_older <= n_older;
            r_prev  <= n_prev;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hpc_queue.sv -----
// Small register FIFO between the front end and the tracker.
`default_nettype none

module hpc_queue
    import hpc_pkg::*;
#(
    parameter int DATA_WIDTH = 36
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic [DATA_WIDTH-1:0] i_data,
    output logic                       o_full,
    output logic                       o_valid,
    output logic [DATA_WIDTH-1:0]      o_data,
    input  wire logic                  i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]      r_count, n_count;

    // Status and head entry
    always_comb begin
        o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
        o_valid = (r_count != '0);
        o_data  = r_mem[r_rd_ptr];
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hpc_back.sv -----
// Back end: hysteresis tracker, peak counter and result register.
`default_nettype none

module hpc_back
    import hpc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_q_valid,
    input  wire t_op_flags                      i_flags,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_cur1,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_cur2,
    output logic                                o_pop,
    input  wire t_cfg                           i_cfg,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [1:0]                          o_verdict,
    output logic [OUT_COUNT_WIDTH-1:0]          o_peak_count
);

    localparam int XW = (SAMPLE_WIDTH > CFG_WIDTH) ? SAMPLE_WIDTH : CFG_WIDTH;
    localparam int VW = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    logic                           r_seek;
    logic signed [SAMPLE_WIDTH-1:0] r_ext;
    logic [COUNT_WIDTH-1:0]         r_peaks;
    logic                           r_out_valid;
    t_verdict                       r_verdict, n_verdict;
    logic [OUT_COUNT_WIDTH-1:0]     r_count_out, n_count_out;

    logic                           seek1, seek2;
    logic signed [SAMPLE_WIDTH-1:0] ext1, ext2;
    logic [COUNT_WIDTH-1:0]         cnt1, cnt2;
    logic                           in_window;

    // One tracker update: count a peak or re-arm, then remember the sample
    function automatic void track_step(
        input  logic                           en,
        input  logic                           seek_in,
        input  logic signed [SAMPLE_WIDTH-1:0] ext_in,
        input  logic [COUNT_WIDTH-1:0]         cnt_in,
        input  logic signed [SAMPLE_WIDTH-1:0] cur,
        input  t_cfg                           cfg,
        output logic                           seek_out,
        output logic signed [SAMPLE_WIDTH-1:0] ext_out,
        output logic [COUNT_WIDTH-1:0]         cnt_out
    );
        logic signed [XW-1:0] ext_x;
        logic signed [XW-1:0] hi_x;
        logic signed [XW-1:0] lo_x;
        ext_x    = XW'(ext_in);
        hi_x     = XW'(cfg.high_threshold);
        lo_x     = XW'(cfg.low_threshold);
        seek_out = seek_in;
        ext_out  = ext_in;
        cnt_out  = cnt_in;
        if (en) begin
            if (seek_in) begin
                if ((cur < ext_in) && (ext_x >= hi_x)) begin
                    seek_out = 1'b0;
                    if (cnt_in != '1) begin
                        cnt_out = cnt_in + 1'b1;
                    end
                end
            end else if ((cur > ext_in) && (ext_x < lo_x)) begin
                seek_out = 1'b1;
            end
            ext_out = cur;
        end
    endfunction

    // Both tracker updates of one entry, then the verdict
    always_comb begin
        track_step(i_flags.op1_valid, r_seek, r_ext, r_peaks, i_cur1, i_cfg,
                   seek1, ext1, cnt1);
        track_step(i_flags.op2_valid, seek1, ext1, cnt1, i_cur2, i_cfg,
                   seek2, ext2, cnt2);

        in_window = (VW'(cnt2) >= VW'(i_cfg.min_peaks)) &&
                    (VW'(cnt2) <= VW'(i_cfg.max_peaks));

        if (i_flags.too_short) begin
            n_verdict   = VERDICT_TOO_SHORT;
            n_count_out = '0;
        end else begin
            n_verdict   = in_window ? VERDICT_HAND : VERDICT_NO_HAND;
            n_count_out = OUT_COUNT_WIDTH'(cnt2);
        end

        // a result entry waits while the output register is held
        o_pop = i_q_valid && (!i_flags.last || !r_out_valid || !i_out_stall);

        o_out_valid  = r_out_valid;
        o_verdict    = r_verdict;
        o_peak_count = r_count_out;
    end

    // Tracker state, cleared at the end of every sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seek  <= 1'b1;
            r_ext   <= '0;
            r_peaks <= '0;
        end else if (o_pop) begin
            if (i_flags.last) begin
                r_seek  <= 1'b1;
                r_ext   <= '0;
                r_peaks <= '0;
            end else begin
                r_seek  <= seek2;
                r_ext   <= ext2;
                r_peaks <= cnt2;
            end
        end
    end

    // Output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_flags.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_flags.last) begin
            r_verdict   <= n_verdict;
            r_count_out <= n_count_out;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hpc_checker.sv -----
// Port-level checker of the peak counter and its bind to the top level.
`default_nettype none

`include "hysteresis_peak_counter_core_defines.svh"

module hpc_checker
    import hpc_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic [1:0]                 o_verdict,
    input wire logic [OUT_COUNT_WIDTH-1:0] o_peak_count
);

    // a held result beat keeps its contents
    `HPC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_verdict) && $stable(o_peak_count), "output beat changed under stall")

    // a too-short sequence reports no peaks
    `HPC_ASSERT(a_short_zero, i_clk, i_rst_n, o_out_valid && (o_verdict == VERDICT_TOO_SHORT) |-> (o_peak_count == '0), "too-short result with nonzero count")

    // reset leaves no result pending and the queue open
    `HPC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "not idle after reset")

endmodule

bind hysteresis_peak_counter_core hpc_checker u_hpc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_verdict    (o_verdict),
    .o_peak_count (o_peak_count)
);

`default_nettype wire
